@@ sv/fuc_pkg.sv @@
// Shared types, constants and the CRC step function for the frame upload checker.
package fuc_pkg;

  localparam int HEADER_BYTES    = 16;
  localparam int FRAME_BUF_BYTES = 131072;
  localparam int HDR_IDX_W       = $clog2(HEADER_BYTES);
  localparam int ADDR_W          = $clog2(FRAME_BUF_BYTES);
  localparam int CNT_W           = 20;
  localparam int LEN_W           = 32;

  localparam logic [CNT_W-1:0] SIZE_MIN = CNT_W'(HEADER_BYTES + 1);
  localparam logic [CNT_W-1:0] SIZE_MAX = CNT_W'(HEADER_BYTES + FRAME_BUF_BYTES);

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  localparam int CFG_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_MAGIC_FIRST    = 3'd0,
    REG_MAGIC_SECOND   = 3'd1,
    REG_VERSION_SCALED = 3'd2,
    REG_VERSION_NATIVE = 3'd3,
    REG_GEOM_A_WIDTH   = 3'd4,
    REG_GEOM_A_HEIGHT  = 3'd5,
    REG_GEOM_B_WIDTH   = 3'd6,
    REG_GEOM_B_HEIGHT  = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    V_OK      = 4'd0,
    V_SIZE    = 4'd1,
    V_SHORT   = 4'd2,
    V_MAGIC   = 4'd3,
    V_VERSION = 4'd4,
    V_LENGTH  = 4'd5,
    V_GEOM    = 4'd6,
    V_TRUNC   = 4'd7,
    V_CRC     = 4'd8
  } verdict_t;

  typedef struct packed {
    logic [7:0]  magic_first;
    logic [7:0]  magic_second;
    logic [7:0]  version_scaled;
    logic [7:0]  version_native;
    logic [15:0] geom_a_width;
    logic [15:0] geom_a_height;
    logic [15:0] geom_b_width;
    logic [15:0] geom_b_height;
  } cfg_t;

  typedef logic [HEADER_BYTES-1:0][7:0] hdr_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ sv/fuc_cfg_regs.sv @@
// Configuration register file with an APB-style access port.
module fuc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fuc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output fuc_pkg::cfg_t                  cfg
);
  import fuc_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_first    <= 8'd0;
      cfg.magic_second   <= 8'd0;
      cfg.version_scaled <= 8'd0;
      cfg.version_native <= 8'd0;
      cfg.geom_a_width   <= 16'd768;
      cfg.geom_a_height  <= 16'd552;
      cfg.geom_b_width   <= 16'd800;
      cfg.geom_b_height  <= 16'd600;
    end else if (wr) begin
      unique case (idx)
        REG_MAGIC_FIRST:    cfg.magic_first    <= pwdata[7:0];
        REG_MAGIC_SECOND:   cfg.magic_second   <= pwdata[7:0];
        REG_VERSION_SCALED: cfg.version_scaled <= pwdata[7:0];
        REG_VERSION_NATIVE: cfg.version_native <= pwdata[7:0];
        REG_GEOM_A_WIDTH:   cfg.geom_a_width   <= pwdata[15:0];
        REG_GEOM_A_HEIGHT:  cfg.geom_a_height  <= pwdata[15:0];
        REG_GEOM_B_WIDTH:   cfg.geom_b_width   <= pwdata[15:0];
        REG_GEOM_B_HEIGHT:  cfg.geom_b_height  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAGIC_FIRST:    prdata = {24'd0, cfg.magic_first};
      REG_MAGIC_SECOND:   prdata = {24'd0, cfg.magic_second};
      REG_VERSION_SCALED: prdata = {24'd0, cfg.version_scaled};
      REG_VERSION_NATIVE: prdata = {24'd0, cfg.version_native};
      REG_GEOM_A_WIDTH:   prdata = {16'd0, cfg.geom_a_width};
      REG_GEOM_A_HEIGHT:  prdata = {16'd0, cfg.geom_a_height};
      REG_GEOM_B_WIDTH:   prdata = {16'd0, cfg.geom_b_width};
      REG_GEOM_B_HEIGHT:  prdata = {16'd0, cfg.geom_b_height};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

@@ sv/fuc_hdr_check.sv @@
// Header validation: magic, version, length against geometry, geometry, declared size.
module fuc_hdr_check (
  input  fuc_pkg::hdr_t                hdr,
  input  fuc_pkg::cfg_t                cfg,
  input  logic [fuc_pkg::CNT_W-1:0]    declared_length,
  output fuc_pkg::verdict_t            result
);
  import fuc_pkg::*;

  logic [15:0]      w;
  logic [15:0]      h;
  logic [LEN_W-1:0] len;
  logic [29:0]      area;
  logic             len_bad;
  logic             geom_ok;
  logic             size_bad;

  assign w        = {hdr[4], hdr[5]};
  assign h        = {hdr[6], hdr[7]};
  assign len      = {hdr[8], hdr[9], hdr[10], hdr[11]};
  assign area     = 30'(w[15:2]) * 30'(h);
  assign len_bad  = (w[1:0] != 2'b00) || (len != LEN_W'(area));
  assign geom_ok  = (w == cfg.geom_a_width && h == cfg.geom_a_height) ||
                    (w == cfg.geom_b_width && h == cfg.geom_b_height);
  assign size_bad = (33'(declared_length) != (33'(len) + 33'(HEADER_BYTES)));

  always_comb begin
    priority if (hdr[0] != cfg.magic_first || hdr[1] != cfg.magic_second) begin
      result = V_MAGIC;
    end else if (hdr[2] != cfg.version_scaled && hdr[2] != cfg.version_native) begin
      result = V_VERSION;
    end else if (len_bad) begin
      result = V_LENGTH;
    end else if (!geom_ok) begin
      result = V_GEOM;
    end else if (size_bad) begin
      result = V_SIZE;
    end else begin
      result = V_OK;
    end
  end

endmodule

@@ sv/frame_upload_checker.sv @@
// Frame upload checker top level: input register, byte processing, result register.
// One byte is taken per cycle and every byte yields exactly one result item; the byte
// waits in the input register until the result register is free (empty or being
// taken), and its result is then loaded there. The pipe keeps one byte per cycle as
// long as the result side takes items. The whole per-byte step (header capture and
// check, the 8-bit unrolled CRC-16 update and the counters) sits between those two
// registers. No clearing pass follows reset.
module frame_upload_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [31:0]                    s_tdata,  // data_byte[7:0], content_length[27:8], zero
  input  logic                           s_tuser,  // start_of_request
  input  logic                           s_tlast,  // end_of_stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // fb_address[16:0], fb_write_data[24:17], verdict[28:25], frame_width[44:29],
  // frame_height[60:45], zero
  output logic [63:0]                    m_tdata,
  output logic                           m_tuser,  // fb_write_enable
  output logic                           m_tlast,  // done_res
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fuc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import fuc_pkg::*;

  cfg_t cfg;

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             in_sor;
  logic             in_eos;
  logic [CNT_W-1:0] in_cl;
  logic             advance;
  logic             fire;

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] byte_counter, byte_counter_next;
  logic [CNT_W-1:0] declared_length, declared_length_next;
  hdr_t             header_store;
  hdr_t             hdr_view;
  logic [15:0]      running_crc, running_crc_next;
  logic [15:0]      accepted_width, accepted_width_next;
  logic [15:0]      accepted_height, accepted_height_next;

  logic             hdr_we;
  logic [HDR_IDX_W-1:0] hdr_idx;
  verdict_t         hdr_result;
  logic [LEN_W-1:0] pay_len;
  logic [15:0]      crc_step;
  logic [CNT_W-1:0] cnt_inc;
  logic             size_bad;
  phase_t           phase_eff;
  logic [CNT_W-1:0] cnt_eff;

  logic             res_we;
  logic [ADDR_W-1:0] res_addr;
  logic [7:0]       res_data;
  logic             res_done;
  verdict_t         res_verdict;

  logic             out_we;
  logic [ADDR_W-1:0] out_addr;
  logic [7:0]       out_data;
  logic             out_done;
  verdict_t         out_verdict;
  logic [15:0]      out_width;
  logic [15:0]      out_height;

  fuc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata[7:0];
      in_cl   <= s_tdata[27:8];
      in_sor  <= s_tuser;
      in_eos  <= s_tlast;
    end
  end

  assign pay_len  = {header_store[8], header_store[9], header_store[10], header_store[11]};
  assign crc_step = crc_byte(running_crc, in_byte);
  assign size_bad = (in_cl < SIZE_MIN) || (in_cl > SIZE_MAX);
  assign hdr_idx  = cnt_eff[HDR_IDX_W-1:0];
  assign cnt_inc  = cnt_eff + CNT_W'(1);

  always_comb begin
    hdr_view = header_store;
    if (hdr_we) begin
      hdr_view[hdr_idx] = in_byte;
    end
  end

  fuc_hdr_check u_hdr (
    .hdr             (hdr_view),
    .cfg             (cfg),
    .declared_length (declared_length_next),
    .result          (hdr_result)
  );

  always_comb begin
    phase_next           = phase;
    byte_counter_next    = byte_counter;
    declared_length_next = declared_length;
    running_crc_next     = running_crc;
    accepted_width_next  = accepted_width;
    accepted_height_next = accepted_height;
    phase_eff            = phase;
    cnt_eff              = byte_counter;
    hdr_we               = 1'b0;
    res_we               = 1'b0;
    res_addr             = '0;
    res_data             = 8'd0;
    res_done             = 1'b0;
    res_verdict          = V_OK;

    if (in_sor) begin
      declared_length_next = in_cl;
      phase_eff            = PH_HEADER;
      cnt_eff              = '0;
      if (size_bad) begin
        phase_eff = PH_IDLE;
      end
    end

    if (in_sor && size_bad) begin
      phase_next  = PH_IDLE;
      res_done    = 1'b1;
      res_verdict = V_SIZE;
    end else begin
      unique case (phase_eff)
        PH_HEADER: begin
          hdr_we            = 1'b1;
          phase_next        = PH_HEADER;
          byte_counter_next = cnt_inc;
          if (cnt_inc >= CNT_W'(HEADER_BYTES)) begin
            if (hdr_result != V_OK) begin
              phase_next  = PH_IDLE;
              res_done    = 1'b1;
              res_verdict = hdr_result;
            end else if (in_eos) begin
              phase_next  = PH_IDLE;
              res_done    = 1'b1;
              res_verdict = V_TRUNC;
            end else begin
              phase_next        = PH_PAYLOAD;
              byte_counter_next = '0;
              running_crc_next  = CRC_INIT;
            end
          end else if (in_eos) begin
            phase_next  = PH_IDLE;
            res_done    = 1'b1;
            res_verdict = V_SHORT;
          end
        end
        PH_PAYLOAD: begin
          res_we            = 1'b1;
          res_addr          = cnt_eff[ADDR_W-1:0];
          res_data          = in_byte;
          running_crc_next  = crc_step;
          byte_counter_next = cnt_inc;
          if (LEN_W'(cnt_inc) >= pay_len) begin
            phase_next = PH_IDLE;
            res_done   = 1'b1;
            if (crc_step == {header_store[12], header_store[13]}) begin
              res_verdict          = V_OK;
              accepted_width_next  = {header_store[4], header_store[5]};
              accepted_height_next = {header_store[6], header_store[7]};
            end else begin
              res_verdict = V_CRC;
            end
          end else if (in_eos) begin
            phase_next  = PH_IDLE;
            res_done    = 1'b1;
            res_verdict = V_TRUNC;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      byte_counter    <= '0;
      declared_length <= '0;
      running_crc     <= CRC_INIT;
      accepted_width  <= 16'd800;
      accepted_height <= 16'd600;
    end else if (fire) begin
      phase           <= phase_next;
      byte_counter    <= byte_counter_next;
      declared_length <= declared_length_next;
      running_crc     <= running_crc_next;
      accepted_width  <= accepted_width_next;
      accepted_height <= accepted_height_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && hdr_we) begin
      header_store[hdr_idx] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_we      <= res_we;
      out_addr    <= res_addr;
      out_data    <= res_data;
      out_done    <= res_done;
      out_verdict <= res_verdict;
      out_width   <= accepted_width_next;
      out_height  <= accepted_height_next;
    end
  end

  assign m_tuser = out_we;
  assign m_tlast = out_done;
  assign m_tdata = {3'd0, out_height, out_width, out_verdict, out_data, out_addr};

`ifndef ASSERT_OFF
  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> LEN_W'(byte_counter) < pay_len)
    else $error("payload count reached length without leaving payload phase");

  a_fire_gives_item: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("processed item did not produce a result");

  a_write_verdict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_we && out_done |->
      (out_verdict == V_OK || out_verdict == V_TRUNC || out_verdict == V_CRC))
    else $error("payload write carries a header verdict");

  a_geom_hold: assert property (@(posedge clk) disable iff (rst)
    fire && !(res_done && res_verdict == V_OK) |=>
      $stable(accepted_width) && $stable(accepted_height))
    else $error("accepted geometry changed without a passing frame");
`endif

endmodule

@@ tb/frame_upload_checker_tb.sv @@
// Self-checking testbench for the frame upload checker: byte stream in, write and verdict items out.
module frame_upload_checker_tb;
  import fuc_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RUN_LIMIT   = 16000000;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic        we;
    logic [16:0] addr;
    logic [7:0]  wdata;
    logic        done;
    verdict_t    verdict;
    logic [15:0] width;
    logic [15:0] height;
  } upload_result_t;

  typedef enum int {
    FF_NONE, FF_MAGIC, FF_VERSION, FF_LENGTH, FF_GEOM, FF_DECL, FF_SHORT,
    FF_TRUNC_HDR, FF_TRUNC, FF_CRC, FF_RESTART, FF_SIZE
  } upload_fault_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [63:0]           m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  cfg_t           cfg_shadow;
  phase_t         up_phase;
  logic [19:0]    up_count;
  logic [19:0]    up_declared;
  logic [7:0]     hdr_shadow [16];
  logic [15:0]    up_crc;
  logic [15:0]    acc_width;
  logic [15:0]    acc_height;
  upload_result_t pending_results [$];

  int snd_idle_pct;
  int rcv_idle_pct;
  int fail_count;
  int items_sent;
  int results_seen;
  int frames_sent;
  int frame_items;
  int cfg_writes;
  int verdict_hits [9];

  frame_upload_checker dut (.*);

  always #CLK_HALF clk = ~clk;

  function automatic logic [15:0] crc16_ccitt_next(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    repeat (8) c = {c[14:0], 1'b0} ^ (c[15] ? CRC_POLY : 16'h0000);
    return c;
  endfunction

  function automatic logic [15:0] hdr_word(int i);
    return {hdr_shadow[i], hdr_shadow[i+1]};
  endfunction

  function automatic logic [31:0] hdr_length();
    return {hdr_shadow[8], hdr_shadow[9], hdr_shadow[10], hdr_shadow[11]};
  endfunction

  function automatic verdict_t header_verdict();
    logic [15:0] w;
    logic [15:0] h;
    logic [31:0] len;
    w = hdr_word(4);
    h = hdr_word(6);
    len = hdr_length();
    if (hdr_shadow[0] != cfg_shadow.magic_first || hdr_shadow[1] != cfg_shadow.magic_second)
      return V_MAGIC;
    if (hdr_shadow[2] != cfg_shadow.version_scaled && hdr_shadow[2] != cfg_shadow.version_native)
      return V_VERSION;
    if (w[1:0] != 2'b00 || 64'(len) != 64'(w >> 2) * 64'(h))
      return V_LENGTH;
    if (!((w == cfg_shadow.geom_a_width && h == cfg_shadow.geom_a_height) ||
          (w == cfg_shadow.geom_b_width && h == cfg_shadow.geom_b_height)))
      return V_GEOM;
    if (64'(up_declared) != 64'(HEADER_BYTES) + 64'(len))
      return V_SIZE;
    return V_OK;
  endfunction

  function automatic upload_result_t predict_upload(logic [7:0] d, bit sor, bit eos,
                                                    logic [19:0] cl);
    upload_result_t r;
    verdict_t       v;
    r.we = 1'b0;
    r.addr = '0;
    r.wdata = '0;
    r.done = 1'b0;
    r.verdict = V_OK;
    if (sor) begin
      up_declared = cl;
      if (cl < SIZE_MIN || cl > SIZE_MAX) begin
        up_phase = PH_IDLE;
        r.done = 1'b1;
        r.verdict = V_SIZE;
      end else begin
        up_phase = PH_HEADER;
        up_count = '0;
      end
    end
    if (up_phase == PH_HEADER) begin
      hdr_shadow[up_count[3:0]] = d;
      up_count = up_count + 20'd1;
      if (up_count >= HEADER_BYTES) begin
        v = header_verdict();
        if (v != V_OK) begin
          up_phase = PH_IDLE;
          r.done = 1'b1;
          r.verdict = v;
        end else if (eos) begin
          up_phase = PH_IDLE;
          r.done = 1'b1;
          r.verdict = V_TRUNC;
        end else begin
          up_phase = PH_PAYLOAD;
          up_count = '0;
          up_crc = CRC_INIT;
        end
      end else if (eos) begin
        up_phase = PH_IDLE;
        r.done = 1'b1;
        r.verdict = V_SHORT;
      end
    end else if (up_phase == PH_PAYLOAD) begin
      r.we = 1'b1;
      r.addr = up_count[16:0];
      r.wdata = d;
      up_crc = crc16_ccitt_next(up_crc, d);
      up_count = up_count + 20'd1;
      if (32'(up_count) >= hdr_length()) begin
        up_phase = PH_IDLE;
        r.done = 1'b1;
        if (up_crc == hdr_word(12)) begin
          r.verdict = V_OK;
          acc_width = hdr_word(4);
          acc_height = hdr_word(6);
        end else begin
          r.verdict = V_CRC;
        end
      end else if (eos) begin
        up_phase = PH_IDLE;
        r.done = 1'b1;
        r.verdict = V_TRUNC;
      end
    end
    r.width = acc_width;
    r.height = acc_height;
    return r;
  endfunction

  task automatic flag_mismatch(string field, longint unsigned expv, longint unsigned actv);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, expv, actv);
  endtask

  task automatic check_result();
    upload_result_t exp_r;
    if (pending_results.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) $error("result item arrived with nothing pending");
      return;
    end
    exp_r = pending_results.pop_front();
    results_seen++;
    if (exp_r.done) verdict_hits[exp_r.verdict]++;
    if (m_tuser !== exp_r.we) flag_mismatch("fb_write_enable", exp_r.we, m_tuser);
    if (m_tdata[16:0] !== exp_r.addr) flag_mismatch("fb_address", exp_r.addr, m_tdata[16:0]);
    if (m_tdata[24:17] !== exp_r.wdata)
      flag_mismatch("fb_write_data", exp_r.wdata, m_tdata[24:17]);
    if (m_tlast !== exp_r.done) flag_mismatch("done_res", exp_r.done, m_tlast);
    if (m_tdata[28:25] !== exp_r.verdict)
      flag_mismatch("verdict", exp_r.verdict, m_tdata[28:25]);
    if (m_tdata[44:29] !== exp_r.width) flag_mismatch("frame_width", exp_r.width, m_tdata[44:29]);
    if (m_tdata[60:45] !== exp_r.height)
      flag_mismatch("frame_height", exp_r.height, m_tdata[60:45]);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result();
    m_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  task automatic push_byte(logic [7:0] d, bit sor, bit eos, logic [19:0] cl);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'h0, cl, d};
    s_tuser <= sor;
    s_tlast <= eos;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_upload(d, sor, eos, cl));
    items_sent++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [15:0] value);
    logic [31:0] stored;
    stored = (idx <= REG_VERSION_NATIVE) ? {24'h0, value[7:0]} : {16'h0, value};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== stored) flag_mismatch("prdata", stored, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MAGIC_FIRST:    cfg_shadow.magic_first = stored[7:0];
      REG_MAGIC_SECOND:   cfg_shadow.magic_second = stored[7:0];
      REG_VERSION_SCALED: cfg_shadow.version_scaled = stored[7:0];
      REG_VERSION_NATIVE: cfg_shadow.version_native = stored[7:0];
      REG_GEOM_A_WIDTH:   cfg_shadow.geom_a_width = stored[15:0];
      REG_GEOM_A_HEIGHT:  cfg_shadow.geom_a_height = stored[15:0];
      REG_GEOM_B_WIDTH:   cfg_shadow.geom_b_width = stored[15:0];
      REG_GEOM_B_HEIGHT:  cfg_shadow.geom_b_height = stored[15:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic apply_config(cfg_t c);
    drain_results();
    cfg_write(REG_MAGIC_FIRST, {8'h00, c.magic_first});
    cfg_write(REG_MAGIC_SECOND, {8'h00, c.magic_second});
    cfg_write(REG_VERSION_SCALED, {8'h00, c.version_scaled});
    cfg_write(REG_VERSION_NATIVE, {8'h00, c.version_native});
    cfg_write(REG_GEOM_A_WIDTH, c.geom_a_width);
    cfg_write(REG_GEOM_A_HEIGHT, c.geom_a_height);
    cfg_write(REG_GEOM_B_WIDTH, c.geom_b_width);
    cfg_write(REG_GEOM_B_HEIGHT, c.geom_b_height);
  endtask

  function automatic int unsigned geom_payload(logic [15:0] w, logic [15:0] h);
    if (w[1:0] != 2'b00) return 0;
    return 32'(w >> 2) * 32'(h);
  endfunction

  function automatic bit small_geom(logic [15:0] w, logic [15:0] h);
    return geom_payload(w, h) >= 1 && geom_payload(w, h) <= 64;
  endfunction

  function automatic upload_fault_t pick_fault();
    if ($urandom_range(99) < 55) return FF_NONE;
    return upload_fault_t'($urandom_range(int'(FF_MAGIC), int'(FF_SIZE)));
  endfunction

  task automatic send_frame(upload_fault_t fault, bit go_large);
    logic [15:0] w;
    logic [15:0] h;
    int unsigned len;
    logic [7:0]  hdr [16];
    logic [7:0]  pay [$];
    logic [15:0] crc;
    logic [19:0] cl;
    logic [7:0]  v;
    int          last;
    bit          end_flag;
    int          k;
    w = cfg_shadow.geom_a_width;
    h = cfg_shadow.geom_a_height;
    if (!go_large && ($urandom_range(1) == 0 || !small_geom(w, h))) begin
      w = cfg_shadow.geom_b_width;
      h = cfg_shadow.geom_b_height;
    end
    if (!go_large && !small_geom(w, h)) begin
      w = cfg_shadow.geom_a_width;
      h = cfg_shadow.geom_a_height;
    end
    if (fault == FF_GEOM) begin
      do begin
        w = 16'(4 * $urandom_range(1, 8));
        h = 16'($urandom_range(1, 8));
      end while ((w == cfg_shadow.geom_a_width && h == cfg_shadow.geom_a_height) ||
                 (w == cfg_shadow.geom_b_width && h == cfg_shadow.geom_b_height));
    end
    len = geom_payload(w, h);
    crc = CRC_INIT;
    repeat (len) begin
      v = 8'($urandom);
      pay.push_back(v);
      crc = crc16_ccitt_next(crc, v);
    end
    hdr[0] = cfg_shadow.magic_first;
    hdr[1] = cfg_shadow.magic_second;
    hdr[2] = $urandom_range(1) ? cfg_shadow.version_scaled : cfg_shadow.version_native;
    hdr[3] = 8'($urandom);
    {hdr[4], hdr[5]} = w;
    {hdr[6], hdr[7]} = h;
    {hdr[8], hdr[9], hdr[10], hdr[11]} = len;
    {hdr[12], hdr[13]} = crc;
    hdr[14] = 8'($urandom);
    hdr[15] = 8'($urandom);
    cl = 20'(HEADER_BYTES + len);
    last = HEADER_BYTES + len - 1;
    end_flag = $urandom_range(1);
    case (fault)
      FF_MAGIC: begin
        k = $urandom_range(1);
        hdr[k] = hdr[k] ^ 8'(1 << $urandom_range(7));
      end
      FF_VERSION: begin
        do v = 8'($urandom);
        while (v == cfg_shadow.version_scaled || v == cfg_shadow.version_native);
        hdr[2] = v;
      end
      FF_LENGTH: begin
        if ($urandom_range(1)) begin
          hdr[5] = hdr[5] | 8'($urandom_range(1, 3));
        end else begin
          k = 8 + $urandom_range(3);
          hdr[k] = hdr[k] ^ 8'(1 << $urandom_range(7));
        end
      end
      FF_DECL: begin
        do cl = 20'($urandom_range(int'(SIZE_MIN), HEADER_BYTES + len + 40));
        while (cl == 20'(HEADER_BYTES + len));
      end
      FF_CRC: begin
        k = 12 + $urandom_range(1);
        hdr[k] = hdr[k] ^ 8'(1 << $urandom_range(7));
      end
      FF_SIZE: begin
        cl = $urandom_range(1) ? 20'($urandom_range(0, HEADER_BYTES))
                               : 20'($urandom_range(int'(SIZE_MAX) + 1, 20'hFFFFF));
        last = $urandom_range(0, 3);
      end
      FF_SHORT: begin
        last = $urandom_range(0, HEADER_BYTES - 2);
        end_flag = 1'b1;
      end
      FF_TRUNC_HDR: begin
        last = HEADER_BYTES - 1;
        end_flag = 1'b1;
      end
      FF_TRUNC: begin
        last = (len >= 2) ? HEADER_BYTES + $urandom_range(0, len - 2) : HEADER_BYTES - 1;
        end_flag = 1'b1;
      end
      FF_RESTART: begin
        last = $urandom_range(0, HEADER_BYTES + len - 2);
        end_flag = 1'b0;
      end
      default: ;
    endcase
    for (k = 0; k <= last; k++) begin
      push_byte(k < HEADER_BYTES ? hdr[k] : pay[k - HEADER_BYTES], k == 0,
                end_flag && k == last, k == 0 ? cl : 20'($urandom));
    end
    frames_sent++;
    if (!go_large) frame_items += last + 1;
    if (fault == FF_RESTART) begin
      send_frame(FF_NONE, 1'b0);
    end else if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0, $urandom_range(1), 20'($urandom));
    end
  endtask

  task automatic directed_test();
    snd_idle_pct = 18;
    rcv_idle_pct = 58;
    push_byte(8'h00, 1'b1, 1'b0, 20'd0);
    push_byte(8'h5A, 1'b1, 1'b0, 20'(HEADER_BYTES));
    push_byte(8'hA5, 1'b1, 1'b0, SIZE_MAX + 20'd1);
    push_byte(8'hFF, 1'b1, 1'b1, 20'hFFFFF);
    push_byte(8'hFF, 1'b0, 1'b1, 20'hFFFFF);
    push_byte(cfg_shadow.magic_first, 1'b1, 1'b0, SIZE_MIN);
    push_byte(cfg_shadow.magic_second, 1'b0, 1'b1, 20'd0);
    push_byte(cfg_shadow.magic_first, 1'b1, 1'b0, SIZE_MIN);
    send_frame(FF_NONE, 1'b0);
    drain_results();
  endtask

  task automatic random_frames_test(int snd_pct, int rcv_pct, int target);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    frame_items = 0;
    while (frame_items < target) send_frame(pick_fault(), 1'b0);
    drain_results();
  endtask

  task automatic size_boundary_test();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    push_byte(8'h11, 1'b1, 1'b1, SIZE_MAX);
    push_byte(8'h22, 1'b1, 1'b1, SIZE_MIN);
    push_byte(8'h33, 1'b1, 1'b0, SIZE_MAX - 20'd1);
    push_byte(8'h44, 1'b0, 1'b1, 20'd0);
    drain_results();
  endtask

  initial begin
    cfg_shadow = {8'h00, 8'h00, 8'h00, 8'h00, 16'd768, 16'd552, 16'd800, 16'd600};
    up_phase = PH_IDLE;
    up_count = '0;
    up_declared = '0;
    foreach (hdr_shadow[i]) hdr_shadow[i] = 8'h00;
    up_crc = CRC_INIT;
    acc_width = 16'd800;
    acc_height = 16'd600;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    fail_count = 0;
    items_sent = 0;
    results_seen = 0;
    frames_sent = 0;
    frame_items = 0;
    cfg_writes = 0;
    foreach (verdict_hits[i]) verdict_hits[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    apply_config({8'hA5, 8'h3C, 8'h01, 8'h02, 16'hFFFF, 16'hFFFF, 16'h0004, 16'h0001});
    directed_test();
    apply_config({8'hFF, 8'h00, 8'hFF, 8'h00, 16'h0008, 16'h0002, 16'h0000, 16'h0000});
    random_frames_test(18, 58, 170);
    apply_config({8'h00, 8'hFF, 8'h80, 8'h7F, 16'h0004, 16'h0001, 16'h0010, 16'h0003});
    random_frames_test(58, 18, 170);
    apply_config({8'h5A, 8'hC3, 8'h00, 8'hFF, 16'h0800, 16'h0100, 16'h000C, 16'h0002});
    size_boundary_test();
    random_frames_test(0, 0, 170);
    repeat (8) @(posedge clk);

    $display("covered %0d bytes in, %0d result items, %0d requests, %0d register writes",
             items_sent, results_seen, frames_sent, cfg_writes);
    $display("verdicts: ok %0d size %0d short %0d magic %0d version %0d length %0d geom %0d %s",
             verdict_hits[V_OK], verdict_hits[V_SIZE], verdict_hits[V_SHORT],
             verdict_hits[V_MAGIC], verdict_hits[V_VERSION], verdict_hits[V_LENGTH],
             verdict_hits[V_GEOM],
             $sformatf("trunc %0d crc %0d", verdict_hits[V_TRUNC], verdict_hits[V_CRC]));
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ frame_upload_checker.f @@
sv/fuc_pkg.sv
sv/fuc_cfg_regs.sv
sv/fuc_hdr_check.sv
sv/frame_upload_checker.sv
tb/frame_upload_checker_tb.sv
